### hw/rtl/frame_refcount_allocator_top_assert.svh
// Assertion macros for the frame allocator checker.
`ifndef FRAME_REFCOUNT_ALLOCATOR_TOP_ASSERT_SVH
`define FRAME_REFCOUNT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define FRA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame allocator check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define FRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame allocator check failed");

`endif

### hw/rtl/fra_pkg.sv
`default_nettype none

package fra_pkg;

    localparam int DEF_FRAME_COUNT = 1024;
    localparam int PAGE_SHIFT      = 12;
    localparam int ADDR_W          = 32;
    localparam int PAGE_W          = ADDR_W - PAGE_SHIFT;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 3;
    localparam int FIDX_W          = 10;
    localparam int COUNT_W         = 8;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam mode_t MODE_ALLOC = 2'd0;
    localparam mode_t MODE_FREE  = 2'd1;
    localparam mode_t MODE_ADD   = 2'd2;

    localparam status_t STAT_OK           = 3'd0;
    localparam status_t STAT_NO_FREE      = 3'd1;
    localparam status_t STAT_RANGE        = 3'd2;
    localparam status_t STAT_ALREADY_FREE = 3'd3;
    localparam status_t STAT_SATURATED    = 3'd4;

    localparam count_t COUNT_MAX = 8'hFF;

endpackage

`default_nettype wire

### hw/rtl/fra_count_ram.sv
`default_nettype none

module fra_count_ram
    import fra_pkg::*;
#(
    parameter int DEPTH = DEF_FRAME_COUNT,
    parameter int AW    = $clog2(DEF_FRAME_COUNT)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire count_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output count_t             rd_data
);

    count_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/frame_refcount_allocator_top.sv
// Reference-counted physical frame allocator.
// Input channel (s_valid/s_ready) takes one word: s_mode (allocate, free,
// add reference) and s_phys_address. Result channel (m_valid/m_ready) gives
// one word per input: m_status, m_frame_address, m_frame_index, m_new_count.
// cfg_wr_en/cfg_wr_data set the frame base address; write only when idle.
// Counts live in a single-port-read, single-port-write RAM (registered read).
// After reset the RAM is cleared, one entry a cycle, with s_ready low.
// Config writes are taken during that pass.
// Steps after acceptance: free/add reference pass S_LOOK, S_RMW and S_DONE;
// out of range or a known-full pool pass S_LOOK and S_DONE; allocate passes
// S_LOOK, then S_SCAN over the in-use frames past the lowest-free hint (one
// RAM read per cycle), then S_DONE.
// One word is in flight at a time; s_ready rises again once its result is
// loaded into the output register, so a new word may be taken while the
// previous result is still waiting. If m_ready is held low, the finished
// result is held internally and the block stalls until the output clears.

`default_nettype none

module frame_refcount_allocator_top
    import fra_pkg::*;
#(
    parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [ADDR_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mode_t             s_mode,
    input  wire logic [ADDR_W-1:0] s_phys_address,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output status_t                m_status,
    output logic [ADDR_W-1:0]      m_frame_address,
    output logic [FIDX_W-1:0]      m_frame_index,
    output count_t                 m_new_count
);

    localparam int IW = $clog2(FRAME_COUNT);

    localparam logic [IW-1:0]     LAST_IDX   = IW'(FRAME_COUNT - 1);
    localparam logic [IW:0]       HINT_FULL  = (IW + 1)'(FRAME_COUNT);
    localparam logic [PAGE_W-1:0] PAGE_LIMIT = PAGE_W'(FRAME_COUNT);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_RMW   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     clr_ptr_reg, clr_ptr_next;
    logic [IW:0]       hint_reg, hint_next;
    logic [ADDR_W-1:0] base_reg;
    mode_t             mode_reg, mode_next;
    logic              below_reg, below_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [IW-1:0]     idx_reg, idx_next;

    status_t           res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [FIDX_W-1:0] res_index_reg, res_index_next;
    count_t            res_count_reg, res_count_next;

    logic              m_valid_reg;
    status_t           m_status_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [FIDX_W-1:0] m_index_reg;
    count_t            m_count_reg;

    logic              ram_we, ram_re;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    count_t            ram_wdata, ram_rdata;

    logic              in_range;
    logic [ADDR_W:0]   diff;
    logic              out_free;

    fra_count_ram #(
        .DEPTH (FRAME_COUNT),
        .AW    (IW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign diff     = {1'b0, s_phys_address} - {1'b0, base_reg};
    assign in_range = !below_reg && (page_reg < PAGE_LIMIT);

    always_comb begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        hint_next       = hint_reg;
        mode_next       = mode_reg;
        below_next      = below_reg;
        page_next       = page_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_index_next  = res_index_reg;
        res_count_next  = res_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;

        case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_ptr_reg;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    below_next = diff[ADDR_W];
                    page_next  = diff[ADDR_W-1:PAGE_SHIFT];
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                res_status_next = STAT_RANGE;
                res_addr_next   = '0;
                res_index_next  = '0;
                res_count_next  = '0;
                state_next      = S_DONE;
                if (mode_reg == MODE_ALLOC) begin
                    if (hint_reg == HINT_FULL) begin
                        res_status_next = STAT_NO_FREE;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = hint_reg[IW-1:0];
                        idx_next   = hint_reg[IW-1:0];
                        state_next = S_SCAN;
                    end
                end else if ((mode_reg == MODE_FREE || mode_reg == MODE_ADD) && in_range) begin
                    ram_re     = 1'b1;
                    ram_raddr  = page_reg[IW-1:0];
                    idx_next   = page_reg[IW-1:0];
                    state_next = S_RMW;
                end
            end
            S_RMW: begin
                res_addr_next  = '0;
                res_index_next = FIDX_W'(idx_reg);
                state_next     = S_DONE;
                if (mode_reg == MODE_FREE) begin
                    if (ram_rdata == '0) begin
                        res_status_next = STAT_ALREADY_FREE;
                        res_count_next  = '0;
                    end else begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata - 1'b1;
                        res_status_next = STAT_OK;
                        res_count_next  = ram_rdata - 1'b1;
                        if (ram_rdata == count_t'(1) && {1'b0, idx_reg} < hint_reg) begin
                            hint_next = {1'b0, idx_reg};
                        end
                    end
                end else begin
                    if (ram_rdata == COUNT_MAX) begin
                        res_status_next = STAT_SATURATED;
                        res_count_next  = COUNT_MAX;
                    end else begin
                        ram_we          = 1'b1;
                        ram_wdata       = ram_rdata + 1'b1;
                        res_status_next = STAT_OK;
                        res_count_next  = ram_rdata + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (ram_rdata == '0) begin
                    ram_we          = 1'b1;
                    ram_wdata       = count_t'(1);
                    res_status_next = STAT_OK;
                    res_addr_next   = base_reg + (ADDR_W'(idx_reg) << PAGE_SHIFT);
                    res_index_next  = FIDX_W'(idx_reg);
                    res_count_next  = count_t'(1);
                    hint_next       = {1'b0, idx_reg} + 1'b1;
                    state_next      = S_DONE;
                end else if (idx_reg == LAST_IDX) begin
                    res_status_next = STAT_NO_FREE;
                    res_addr_next   = '0;
                    res_index_next  = '0;
                    res_count_next  = '0;
                    hint_next       = HINT_FULL;
                    state_next      = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_ptr_reg <= '0;
            hint_reg    <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            hint_reg    <= hint_next;
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        below_reg      <= below_next;
        page_reg       <= page_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_index_reg  <= res_index_next;
        res_count_reg  <= res_count_next;
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
            m_index_reg  <= res_index_reg;
            m_count_reg  <= res_count_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_frame_address = m_addr_reg;
    assign m_frame_index   = m_index_reg;
    assign m_new_count     = m_count_reg;

endmodule

`default_nettype wire

### hw/rtl/fra_checker.sv
`default_nettype none

`include "frame_refcount_allocator_top_assert.svh"

module fra_checker
    import fra_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire mode_t             s_mode,
    input wire logic [ADDR_W-1:0] s_phys_address,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire status_t           m_status,
    input wire logic [ADDR_W-1:0] m_frame_address,
    input wire logic [FIDX_W-1:0] m_frame_index,
    input wire count_t            m_new_count
);

    logic [MODE_W+ADDR_W-1:0]                  s_word;
    logic [STATUS_W+ADDR_W+FIDX_W+COUNT_W-1:0] m_word;
    logic                                      m_failed;

    assign s_word   = {s_mode, s_phys_address};
    assign m_word   = {m_status, m_frame_address, m_frame_index, m_new_count};
    assign m_failed = (m_status == STAT_NO_FREE) || (m_status == STAT_RANGE);

    // waiting input word holds
    `FRA_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_word))

    // stalled result word holds
    `FRA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_word))

    // only a successful result can carry an address
    `FRA_ASSERT_NOW(a_addr_only_ok, m_valid && m_status != STAT_OK, m_frame_address == '0)

    `FRA_ASSERT_NOW(a_fail_zeroes, m_valid && m_failed, m_frame_index == '0 && m_new_count == '0)

    `FRA_ASSERT_NOW(a_free_count, m_valid && m_status == STAT_ALREADY_FREE, m_new_count == '0)

endmodule

bind frame_refcount_allocator_top fra_checker u_fra_checker (.*);

`default_nettype wire

### dv/frame_refcount_allocator_checker.sv
`default_nettype none

module frame_refcount_allocator_checker
    import fra_pkg::*;
#(
    parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [ADDR_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire mode_t             s_mode,
    input  wire logic [ADDR_W-1:0] s_phys_address,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire status_t           m_status,
    input  wire logic [ADDR_W-1:0] m_frame_address,
    input  wire logic [FIDX_W-1:0] m_frame_index,
    input  wire count_t            m_new_count,
    output int unsigned            n_fail
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   frame_address;
        logic [FIDX_W-1:0]   frame_index;
        count_t              new_count;
    } frame_result_t;

    count_t            frame_refs [FRAME_COUNT];
    logic [ADDR_W-1:0] frame_base;
    frame_result_t     pending_results [$];

    // Applies one request to the shadow counts and gives the word it should produce.
    function automatic frame_result_t apply_request(mode_t mode, logic [ADDR_W-1:0] addr);
        frame_result_t     res;
        logic [ADDR_W-1:0] offset;
        int unsigned       idx;
        bit                found;
        res   = '0;
        found = 1'b0;
        if (mode == MODE_ALLOC) begin
            res.status = STAT_NO_FREE;
            for (int i = 0; i < FRAME_COUNT && !found; i++) begin
                if (frame_refs[i] == '0) begin
                    found             = 1'b1;
                    frame_refs[i]     = count_t'(1);
                    res.status        = STAT_OK;
                    res.frame_address = frame_base + (ADDR_W'(i) << PAGE_SHIFT);
                    res.frame_index   = FIDX_W'(i);
                    res.new_count     = count_t'(1);
                end
            end
            return res;
        end
        offset = addr - frame_base;
        if ((mode != MODE_FREE && mode != MODE_ADD) || addr < frame_base ||
            (offset >> PAGE_SHIFT) >= FRAME_COUNT) begin
            res.status = STAT_RANGE;
            return res;
        end
        idx             = offset >> PAGE_SHIFT;
        res.frame_index = FIDX_W'(idx);
        if (mode == MODE_FREE) begin
            if (frame_refs[idx] == '0) begin
                res.status = STAT_ALREADY_FREE;
            end else begin
                frame_refs[idx] = frame_refs[idx] - count_t'(1);
                res.status      = STAT_OK;
                res.new_count   = frame_refs[idx];
            end
        end else if (frame_refs[idx] == COUNT_MAX) begin
            res.status    = STAT_SATURATED;
            res.new_count = COUNT_MAX;
        end else begin
            frame_refs[idx] = frame_refs[idx] + count_t'(1);
            res.status      = STAT_OK;
            res.new_count   = frame_refs[idx];
        end
        return res;
    endfunction

    function automatic void check_field(string field, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        frame_result_t want;
        if (!aresetn) begin
            foreach (frame_refs[i]) frame_refs[i] = '0;
            frame_base = '0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing outstanding");
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", ADDR_W'(want.status), ADDR_W'(m_status));
                    check_field("frame_address", want.frame_address, m_frame_address);
                    check_field("frame_index", ADDR_W'(want.frame_index), ADDR_W'(m_frame_index));
                    check_field("new_count", ADDR_W'(want.new_count), ADDR_W'(m_new_count));
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_request(s_mode, s_phys_address));
            end
            if (cfg_wr_en) begin
                frame_base = cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

### dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fra_pkg::*;

    localparam int          IDLE_PCT    = 26;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam mode_t       MODE_UNUSED = 2'd3;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              cfg_wr_en      = 1'b0;
    logic [ADDR_W-1:0] cfg_wr_data    = '0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    mode_t             s_mode         = MODE_ALLOC;
    logic [ADDR_W-1:0] s_phys_address = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    status_t           m_status;
    logic [ADDR_W-1:0] m_frame_address;
    logic [FIDX_W-1:0] m_frame_index;
    count_t            m_new_count;

    bit          calm    = 1'b0;
    int unsigned n_sent  = 0;
    int unsigned n_recv  = 0;
    int unsigned cycles  = 0;
    int unsigned n_fail;

    frame_refcount_allocator_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_phys_address  (s_phys_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_frame_address (m_frame_address),
        .m_frame_index   (m_frame_index),
        .m_new_count     (m_new_count)
    );

    frame_refcount_allocator_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_phys_address  (s_phys_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_frame_address (m_frame_address),
        .m_frame_index   (m_frame_index),
        .m_new_count     (m_new_count),
        .n_fail          (n_fail)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            n_recv <= n_recv + 1;
        end
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[frame_refcount_allocator_top] ERROR");
            $finish;
        end
    end

    task automatic send_word(mode_t mode, logic [ADDR_W-1:0] addr);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_phys_address <= addr;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    // Drain, let the block settle, then move the frame base.
    task automatic set_base(logic [ADDR_W-1:0] base);
        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] frame_addr(logic [ADDR_W-1:0] base, int unsigned idx);
        return base + (ADDR_W'(idx) << PAGE_SHIFT) + ADDR_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_target(logic [ADDR_W-1:0] base);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return frame_addr(base, $urandom_range(0, 47));
        if (r < 80) return frame_addr(base, $urandom_range(1020, 1027));
        if (r < 88) return base - ADDR_W'($urandom_range(1, 8192));
        return $urandom;
    endfunction

    task automatic random_word(logic [ADDR_W-1:0] base, int unsigned alloc_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            send_word(MODE_ALLOC, $urandom);
        end else if (r < 97) begin
            send_word($urandom_range(0, 1) ? MODE_FREE : MODE_ADD, pick_target(base));
        end else begin
            send_word(MODE_UNUSED, $urandom);
        end
    endtask

    initial begin
        int unsigned sat_frame;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_base(32'h0000_0000);
        send_word(MODE_ALLOC, 32'h0000_0000);
        send_word(MODE_ALLOC, 32'hFFFF_FFFF);
        send_word(MODE_ADD, 32'h0000_0FFF);
        send_word(MODE_FREE, 32'h0000_0000);
        send_word(MODE_FREE, 32'h0000_0ABC);
        send_word(MODE_FREE, 32'h0000_0000);
        send_word(MODE_ALLOC, 32'h5555_5555);
        send_word(MODE_ADD, 32'h003F_F000);
        send_word(MODE_ADD, 32'h003F_FFFF);
        send_word(MODE_FREE, 32'h003F_F800);
        send_word(MODE_FREE, 32'h003F_F000);
        send_word(MODE_FREE, 32'h003F_F123);
        send_word(MODE_ADD, 32'h0040_0000);
        send_word(MODE_FREE, 32'hFFFF_FFFF);
        send_word(MODE_UNUSED, 32'h0000_0000);
        send_word(MODE_UNUSED, 32'hFFFF_FFFF);
        send_word(MODE_FREE, 32'h0000_1000);
        send_word(MODE_ALLOC, 32'hAAAA_AAAA);

        // unaligned base: low bits carried into every address
        set_base(32'h1234_5678);
        send_word(MODE_FREE, 32'h1234_5677);
        send_word(MODE_ADD, 32'h1234_5678);
        send_word(MODE_ALLOC, 32'h0000_0000);
        repeat (40) random_word(32'h1234_5678, 40);

        // drive one frame into saturation, both sides flat out
        set_base(32'h8000_0000);
        calm      <= 1'b1;
        sat_frame  = $urandom_range(0, 1023);
        repeat (262) send_word(MODE_ADD, frame_addr(32'h8000_0000, sat_frame));
        send_word(MODE_FREE, frame_addr(32'h8000_0000, sat_frame));
        send_word(MODE_ADD, frame_addr(32'h8000_0000, sat_frame));
        send_word(MODE_ADD, frame_addr(32'h8000_0000, sat_frame));
        calm      <= 1'b0;

        // top base: allocated addresses wrap; run the pool dry
        set_base(32'hFFFF_F000);
        repeat (1080) random_word(32'hFFFF_F000, 96);

        set_base(32'h0000_0000);
        repeat (30) random_word(32'h0000_0000, 30);

        s_valid <= 1'b0;
        while (n_recv != n_sent) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (n_fail == 0) begin
            $display("[frame_refcount_allocator_top] OK");
        end else begin
            $display("[frame_refcount_allocator_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+hw/rtl
hw/rtl/fra_pkg.sv
hw/rtl/fra_count_ram.sv
hw/rtl/frame_refcount_allocator_top.sv
hw/rtl/fra_checker.sv
dv/frame_refcount_allocator_checker.sv
dv/tb.sv
